// ===== rtl/bge_pkg.sv =====
// ----------------------------------------------------------------------------
// bge_pkg: shared definitions for the button gesture event queue
// Operation codes, event codes, the poll and ring response structs, the output
// queue geometry and the configuration register reset values and indexes.
// ----------------------------------------------------------------------------
package bge_pkg;

	// default number of ring slots (the ring holds one less)
	localparam int RING_SLOTS_DEF = 16;

	// output queue geometry
	localparam int OQ_DEPTH = 4;
	localparam int OQ_IW    = 2;

	// configuration register reset values
	localparam logic [15:0] LONG_PRESS_RST = 16'd800;
	localparam logic [15:0] TALK_ARM_RST   = 16'd500;

	// configuration register indexes
	localparam logic REG_LONG_PRESS = 1'b0;
	localparam logic REG_TALK_ARM   = 1'b1;

	// input operation codes
	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_UP    = 3'd1,
		OP_DOWN  = 3'd2,
		OP_FUNC  = 3'd3,
		OP_BOOT  = 3'd4,
		OP_POWER = 3'd5,
		OP_POLL  = 3'd6
	} op_t;

	// queued event codes
	typedef enum logic [3:0] {
		EV_NONE       = 4'd0,
		EV_UP         = 4'd1,
		EV_DOWN       = 4'd2,
		EV_SELECT     = 4'd3,
		EV_BACK       = 4'd4,
		EV_POWER      = 4'd5,
		EV_HOME       = 4'd6,
		EV_TALK_START = 4'd7,
		EV_TALK_STOP  = 4'd8
	} ev_code_t;

	// poll request from the control into the ring read stage
	typedef struct packed {
		logic valid;
		logic empty;
	} poll_req_t;

	// poll response from the ring read stage into the output queue
	typedef struct packed {
		logic     valid;
		ev_code_t code;
	} ring_rsp_t;

endpackage

// ===== rtl/bge_ring.sv =====
// ----------------------------------------------------------------------------
// bge_ring: event ring memory
// One write port and one registered read port; the read stage turns a poll
// into a response, answering none when the ring was empty.
// ----------------------------------------------------------------------------
module bge_ring #(
	parameter int RING_SLOTS = bge_pkg::RING_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wen,
	input  logic [$clog2(RING_SLOTS)-1:0] waddr,
	input  bge_pkg::ev_code_t             wdata,
	input  logic                          ren,
	input  logic [$clog2(RING_SLOTS)-1:0] raddr,
	input  bge_pkg::poll_req_t            poll,
	output bge_pkg::ring_rsp_t            rsp
);

	logic [3:0] mem [RING_SLOTS];
	logic [3:0] rdata_s1;
	logic       valid_s1;
	logic       empty_s1;

	// ring storage, write and registered read
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= 4'(wdata);
		end
		if (ren) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// poll stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			empty_s1 <= 1'b0;
		end else begin
			valid_s1 <= poll.valid;
			empty_s1 <= poll.empty;
		end
	end

	// response, none for an empty ring
	always_comb begin
		rsp.valid = valid_s1;
		rsp.code  = empty_s1 ? bge_pkg::EV_NONE : bge_pkg::ev_code_t'(rdata_s1);
	end

endmodule

// ===== rtl/bge_outq.sv =====
// ----------------------------------------------------------------------------
// bge_outq: poll response queue
// Small queue between the ring read stage and the output channel, with a
// credit that covers the response still in the read stage.
// ----------------------------------------------------------------------------
module bge_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  bge_pkg::ring_rsp_t rsp,
	output logic               credit,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         event_code
);

	logic [3:0]              data_q [bge_pkg::OQ_DEPTH];
	logic [bge_pkg::OQ_IW-1:0] wr_q;
	logic [bge_pkg::OQ_IW-1:0] rd_q;
	logic [bge_pkg::OQ_IW:0]   cnt_q;
	logic                      push;
	logic                      pop;

	// handshake and credit
	assign push       = rsp.valid;
	assign pop        = out_valid && !out_stall;
	assign out_valid  = (cnt_q != '0);
	assign event_code = data_q[rd_q];
	assign credit     = ({1'b0, cnt_q} + {{(bge_pkg::OQ_IW+1){1'b0}}, rsp.valid})
		< (bge_pkg::OQ_IW+2)'(bge_pkg::OQ_DEPTH);

	// queue entries
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_q] <= 4'(rsp.code);
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	// a response pushed without a pop never finds the queue full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q < (bge_pkg::OQ_IW+1)'(bge_pkg::OQ_DEPTH))
		else $error("response pushed into full output queue");

	// the count never exceeds the depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (bge_pkg::OQ_IW+1)'(bge_pkg::OQ_DEPTH))
		else $error("output queue count out of range");
`endif

endmodule

// ===== rtl/bge_ctrl.sv =====
// ----------------------------------------------------------------------------
// bge_ctrl: gesture tracking and ring pointers
// Decodes each request, updates the button state, issues ring writes and
// reads, and holds the second event of a tick for the following cycle.
// ----------------------------------------------------------------------------
module bge_ctrl #(
	parameter int RING_SLOTS = bge_pkg::RING_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    opcode,
	input  logic                          pressed,
	input  logic [31:0]                   now_ms,
	input  logic [15:0]                   long_press_ms,
	input  logic [15:0]                   talk_arm_ms,
	input  logic                          credit,
	output logic                          wen,
	output logic [$clog2(RING_SLOTS)-1:0] waddr,
	output bge_pkg::ev_code_t             wdata,
	output logic                          ren,
	output logic [$clog2(RING_SLOTS)-1:0] raddr,
	output bge_pkg::poll_req_t            poll
);

	localparam int IW = $clog2(RING_SLOTS);
	localparam logic [IW-1:0] LAST = IW'(RING_SLOTS - 1);

	logic              func_held_q, func_held_d;
	logic [31:0]       func_time_q, func_time_d;
	logic              func_long_q, func_long_d;
	logic              boot_held_q, boot_held_d;
	logic [31:0]       boot_time_q, boot_time_d;
	logic              talk_armed_q, talk_armed_d;
	logic              power_ready_q, power_ready_d;
	logic [IW-1:0]     rd_q, rd_d;
	logic [IW-1:0]     wr_q, wr_d;
	logic              pend_q, pend_d;

	logic              fire;
	logic              func_due;
	logic              boot_due;
	logic              ev_valid;
	bge_pkg::ev_code_t ev_code;
	logic              enq;
	bge_pkg::ev_code_t enq_code;
	logic [IW-1:0]     wr_next;
	logic [IW-1:0]     rd_next;
	logic              full;
	logic              empty;

	function automatic logic op_is_poll(logic [2:0] op);
		return op == 3'(bge_pkg::OP_POLL);
	endfunction

	// accept unless a held event owns the ring port or a poll has no credit
	assign in_stall = pend_q || (op_is_poll(opcode) && !credit);
	assign fire     = in_valid && !in_stall;

	// hold time compares, wrapping difference
	assign func_due = (now_ms - func_time_q) >= {16'b0, long_press_ms};
	assign boot_due = (now_ms - boot_time_q) >= {16'b0, talk_arm_ms};

	// request decode and button state
	always_comb begin
		func_held_d   = func_held_q;
		func_time_d   = func_time_q;
		func_long_d   = func_long_q;
		boot_held_d   = boot_held_q;
		boot_time_d   = boot_time_q;
		talk_armed_d  = talk_armed_q;
		power_ready_d = power_ready_q;
		pend_d        = 1'b0;
		ev_valid      = 1'b0;
		ev_code       = bge_pkg::EV_NONE;
		if (fire) begin
			unique case (bge_pkg::op_t'(opcode))
				bge_pkg::OP_TICK: begin
					if (func_held_q && !func_long_q && func_due) begin
						ev_valid    = 1'b1;
						ev_code     = bge_pkg::EV_HOME;
						func_long_d = 1'b1;
					end
					if (boot_held_q && !talk_armed_q && boot_due) begin
						talk_armed_d = 1'b1;
						if (ev_valid) begin
							pend_d = 1'b1;
						end else begin
							ev_valid = 1'b1;
							ev_code  = bge_pkg::EV_TALK_START;
						end
					end
				end
				bge_pkg::OP_UP: begin
					ev_valid = pressed;
					ev_code  = bge_pkg::EV_UP;
				end
				bge_pkg::OP_DOWN: begin
					ev_valid = pressed;
					ev_code  = bge_pkg::EV_DOWN;
				end
				bge_pkg::OP_FUNC: begin
					if (pressed) begin
						if (!func_held_q) begin
							func_held_d = 1'b1;
							func_time_d = now_ms;
							func_long_d = 1'b0;
						end
					end else if (func_held_q) begin
						func_held_d = 1'b0;
						ev_valid    = !func_long_q;
						ev_code     = bge_pkg::EV_SELECT;
					end
				end
				bge_pkg::OP_BOOT: begin
					if (pressed) begin
						if (!boot_held_q) begin
							boot_held_d  = 1'b1;
							boot_time_d  = now_ms;
							talk_armed_d = 1'b0;
						end
					end else if (boot_held_q) begin
						boot_held_d  = 1'b0;
						talk_armed_d = 1'b0;
						ev_valid     = 1'b1;
						ev_code      = talk_armed_q ? bge_pkg::EV_TALK_STOP : bge_pkg::EV_BACK;
					end
				end
				bge_pkg::OP_POWER: begin
					if (pressed) begin
						if (power_ready_q) begin
							ev_valid      = 1'b1;
							ev_code       = bge_pkg::EV_POWER;
							power_ready_d = 1'b0;
						end
					end else begin
						power_ready_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ring write, held talk start goes first
	assign wr_next  = (wr_q == LAST) ? '0 : wr_q + 1'b1;
	assign rd_next  = (rd_q == LAST) ? '0 : rd_q + 1'b1;
	assign full     = (wr_next == rd_q);
	assign empty    = (rd_q == wr_q);
	assign enq      = pend_q || ev_valid;
	assign enq_code = pend_q ? bge_pkg::EV_TALK_START : ev_code;
	assign wen      = enq && !full;
	assign waddr    = wr_q;
	assign wdata    = enq_code;
	assign wr_d     = wen ? wr_next : wr_q;

	// ring read for a poll
	assign poll  = {fire && op_is_poll(opcode), empty};
	assign ren   = poll.valid && !empty;
	assign raddr = rd_q;
	assign rd_d  = ren ? rd_next : rd_q;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_held_q   <= 1'b0;
			func_time_q   <= '0;
			func_long_q   <= 1'b0;
			boot_held_q   <= 1'b0;
			boot_time_q   <= '0;
			talk_armed_q  <= 1'b0;
			power_ready_q <= 1'b0;
			rd_q          <= '0;
			wr_q          <= '0;
			pend_q        <= 1'b0;
		end else begin
			func_held_q   <= func_held_d;
			func_time_q   <= func_time_d;
			func_long_q   <= func_long_d;
			boot_held_q   <= boot_held_d;
			boot_time_q   <= boot_time_d;
			talk_armed_q  <= talk_armed_d;
			power_ready_q <= power_ready_d;
			rd_q          <= rd_d;
			wr_q          <= wr_d;
			pend_q        <= pend_d;
		end
	end

`ifndef SYNTHESIS
	// a held event blocks new requests
	a_pend_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> in_stall)
		else $error("request accepted while an event is held");

	// a held event lasts exactly one cycle
	a_pend_once: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> !pend_q)
		else $error("held event not written in one cycle");

	// ring read and write never touch the same entry together
	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		wen && ren |-> waddr != raddr)
		else $error("ring read and write on the same entry");
`endif

endmodule

// ===== rtl/button_gesture_event_queue.sv =====
// ----------------------------------------------------------------------------
// button_gesture_event_queue: button gestures into a polled event ring
// Top level with the configuration registers, the gesture control, the event
// ring and the poll response queue.
// ----------------------------------------------------------------------------
// The block takes one request per clock while in_stall is low. A tick that
// fires both Home and talk start writes the second event in the following
// cycle, through the single ring write port, and holds off the next request
// until then. A poll result passes through the ring read register and then
// the response queue, which has four entries, and polls wait while
// queued and in-flight results fill it. The ring keeps RING_SLOTS - 1 events
// and drops new events when full; a poll of an empty ring answers none.
// Registers at byte address 0 (long press time) and 4 (talk arm time).
module button_gesture_event_queue #(
	parameter int RING_SLOTS = bge_pkg::RING_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic        pressed,
	input  logic [31:0] now_ms,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  event_code,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = $clog2(RING_SLOTS);

	logic [15:0]        long_press_q;
	logic [15:0]        talk_arm_q;
	logic               credit;
	logic               wen;
	logic [IW-1:0]      waddr;
	bge_pkg::ev_code_t  wdata;
	logic               ren;
	logic [IW-1:0]      raddr;
	bge_pkg::poll_req_t poll;
	bge_pkg::ring_rsp_t rsp;

	// configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= bge_pkg::LONG_PRESS_RST;
			talk_arm_q   <= bge_pkg::TALK_ARM_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == bge_pkg::REG_TALK_ARM) begin
				talk_arm_q <= pwdata[15:0];
			end else begin
				long_press_q <= pwdata[15:0];
			end
		end
	end

	// register read back
	assign prdata = (paddr[2] == bge_pkg::REG_LONG_PRESS) ? {16'b0, long_press_q}
		: {16'b0, talk_arm_q};

	bge_ctrl #(
		.RING_SLOTS(RING_SLOTS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.pressed      (pressed),
		.now_ms       (now_ms),
		.long_press_ms(long_press_q),
		.talk_arm_ms  (talk_arm_q),
		.credit       (credit),
		.wen          (wen),
		.waddr        (waddr),
		.wdata        (wdata),
		.ren          (ren),
		.raddr        (raddr),
		.poll         (poll)
	);

	bge_ring #(
		.RING_SLOTS(RING_SLOTS)
	) u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.wen   (wen),
		.waddr (waddr),
		.wdata (wdata),
		.ren   (ren),
		.raddr (raddr),
		.poll  (poll),
		.rsp   (rsp)
	);

	bge_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.rsp       (rsp),
		.credit    (credit),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_code(event_code)
	);

endmodule
